// ----- rtl/core/terrain_splat_weight_kernel_top_defines.svh -----
// Assertion macros for the terrain splat weight kernel checker.
`ifndef TERRAIN_SPLAT_WEIGHT_KERNEL_TOP_DEFINES_SVH
`define TERRAIN_SPLAT_WEIGHT_KERNEL_TOP_DEFINES_SVH

// same-cycle implication
`define TSWK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tswk assertion failed");

// next-cycle implication
`define TSWK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tswk assertion failed");

`endif

// ----- rtl/core/tswk_pkg.sv -----
// Package: constants and types shared by the terrain splat weight kernel.
package tswk_pkg;

	localparam int NORM_BITS   = 16;
	localparam int SCALE_BITS  = 8;
	localparam int RAMP_STAGES = 5;
	localparam int PIPE_DEPTH  = NORM_BITS + 1 + RAMP_STAGES + SCALE_BITS + 1;

	localparam logic [1:0] CFG_ELEV_MIN   = 2'd0;
	localparam logic [1:0] CFG_ELEV_RANGE = 2'd1;
	localparam logic [1:0] CFG_SLOPE_MAX  = 2'd2;

	localparam logic [15:0] ELEV_MIN_RST   = 16'd0;
	localparam logic [15:0] ELEV_RANGE_RST = 16'd65535;
	localparam logic [15:0] SLOPE_MAX_RST  = 16'd65535;

	localparam logic [20:0] ONE      = 21'd65536;
	localparam logic [20:0] HALF     = 21'd32768;
	localparam logic [20:0] ONE_X7   = 21'd458752;
	localparam logic [20:0] ONE_X8   = 21'd524288;
	localparam logic [20:0] ONE_X11  = 21'd720896;
	localparam logic [16:0] GRASS_FLOOR = 17'd3277;

	// ceil(2^32 / d), exact floor division for numerators below 2^21
	localparam logic [51:0] RECIP3 = 52'd1431655766;
	localparam logic [51:0] RECIP7 = 52'd613566757;
	localparam logic [51:0] RECIP9 = 52'd477218589;

	typedef struct packed {
		logic [16:0] grass;
		logic [16:0] rock;
		logic [16:0] dirt;
		logic [16:0] sand;
	} weights_t;

endpackage

// ----- rtl/core/tswk_norm_div.sv -----
// Pipelined fractional divider: min(num * 2^16 / den, 2^16), one quotient bit per stage.
module tswk_norm_div (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] num,
	input  logic [15:0] den,
	output logic [16:0] q
);

	localparam int NB = tswk_pkg::NORM_BITS;

	logic [15:0] den_eff;
	logic [15:0] rem_s [0:NB];
	logic [15:0] quo_s [0:NB];
	logic        sat_s [0:NB];

	assign den_eff = (den == 16'd0) ? 16'd1 : den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			sat_s[0] <= (num >= den_eff);
		end
	end

	for (genvar k = 1; k <= NB; k++) begin : g_stage
		logic [16:0] dbl;
		logic        bit_k;
		assign dbl   = {rem_s[k-1], 1'b0};
		assign bit_k = (dbl >= {1'b0, den_eff});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= bit_k ? 16'(dbl - {1'b0, den_eff}) : dbl[15:0];
				quo_s[k] <= {quo_s[k-1][14:0], bit_k};
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign q = sat_s[NB] ? 17'h10000 : {1'b0, quo_s[NB]};

endmodule

// ----- rtl/core/tswk_ramp.sv -----
// Ramp stages: raw sand, dirt, grass and rock weights and their total.
module tswk_ramp (
	input  logic               clk,
	input  logic               en,
	input  logic [16:0]        e,
	input  logic [16:0]        s,
	output tswk_pkg::weights_t w,
	output logic [18:0]        total
);

	logic [20:0] e5, e10, e20, s2, s4, s10;
	logic [16:0] sand_a, sfd_a;
	logic [19:0] da_a, dbn_a, r2n_a;
	logic [20:0] gan_a;
	logic [18:0] gb_a, sgn_a;
	logic [17:0] r1n_a;

	assign e5  = {2'b0, e, 2'b0} + {4'b0, e};
	assign e10 = {e5[19:0], 1'b0};
	assign e20 = {e5[18:0], 2'b0};
	assign s2  = {3'b0, s, 1'b0};
	assign s4  = {2'b0, s, 2'b0};
	assign s10 = {1'b0, s, 3'b0} + {3'b0, s, 1'b0};

	always_comb begin
		sand_a = (e5 < tswk_pkg::ONE) ? 17'(tswk_pkg::ONE - e5) : 17'd0;
		da_a   = (e10 > tswk_pkg::HALF) ? 20'(e10 - tswk_pkg::HALF) : 20'd0;
		dbn_a  = (e20 < tswk_pkg::ONE_X8) ? 20'(tswk_pkg::ONE_X8 - e20) : 20'd0;
		sfd_a  = (s2 < tswk_pkg::ONE) ? 17'(tswk_pkg::ONE - s2) : 17'd0;
		gan_a  = (e20 > tswk_pkg::ONE) ? (e20 - tswk_pkg::ONE) : 21'd0;
		gb_a   = (e10 < tswk_pkg::ONE_X7) ? 19'((tswk_pkg::ONE_X7 - e10) >> 1) : 19'd0;
		sgn_a  = (s10 < tswk_pkg::ONE_X7) ? 19'(tswk_pkg::ONE_X7 - s10) : 19'd0;
		r1n_a  = (s4 > tswk_pkg::ONE) ? 18'(s4 - tswk_pkg::ONE) : 18'd0;
		r2n_a  = (e20 > tswk_pkg::ONE_X11) ? 20'(e20 - tswk_pkg::ONE_X11) : 20'd0;
	end

	// stage 1: ramp numerators
	logic [16:0] sand_s1, sfd_s1;
	logic [19:0] da_s1, dbn_s1, r2n_s1;
	logic [20:0] gan_s1;
	logic [18:0] gb_s1, sgn_s1;
	logic [17:0] r1n_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sand_s1 <= sand_a;
			sfd_s1  <= sfd_a;
			da_s1   <= da_a;
			dbn_s1  <= dbn_a;
			gan_s1  <= gan_a;
			gb_s1   <= gb_a;
			sgn_s1  <= sgn_a;
			r1n_s1  <= r1n_a;
			r2n_s1  <= r2n_a;
		end
	end

	// stage 2: constant divisions by reciprocal
	logic [51:0] pdb, pga, psg, pr1, pr2;
	assign pdb = 52'(dbn_s1) * tswk_pkg::RECIP3;
	assign pga = 52'(gan_s1) * tswk_pkg::RECIP3;
	assign psg = 52'(sgn_s1) * tswk_pkg::RECIP7;
	assign pr1 = 52'(r1n_s1) * tswk_pkg::RECIP3;
	assign pr2 = 52'(r2n_s1) * tswk_pkg::RECIP9;

	logic [16:0] sand_s2, sfd_s2, sg_s2, r1_s2, r2_s2;
	logic [19:0] da_s2;
	logic [17:0] db_s2;
	logic [18:0] ga_s2, gb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sand_s2 <= sand_s1;
			sfd_s2  <= sfd_s1;
			da_s2   <= da_s1;
			gb_s2   <= gb_s1;
			db_s2   <= pdb[49:32];
			ga_s2   <= pga[50:32];
			sg_s2   <= psg[48:32];
			r1_s2   <= pr1[48:32];
			r2_s2   <= pr2[48:32];
		end
	end

	// stage 3: ramp minima and rock maximum
	logic [19:0] dmin;
	logic [18:0] gmin;
	assign dmin = (da_s2 < {2'b0, db_s2}) ? da_s2 : {2'b0, db_s2};
	assign gmin = (ga_s2 < gb_s2) ? ga_s2 : gb_s2;

	logic [16:0] sand_s3, sfd_s3, sg_s3, rock_s3, dirte_s3, grase_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sand_s3  <= sand_s2;
			sfd_s3   <= sfd_s2;
			sg_s3    <= sg_s2;
			rock_s3  <= (r1_s2 > r2_s2) ? r1_s2 : r2_s2;
			dirte_s3 <= dmin[16:0];
			grase_s3 <= gmin[16:0];
		end
	end

	// stage 4: slope factors
	logic [33:0] pdirt, pgrass;
	logic [16:0] grass_raw;
	assign pdirt     = 34'(dirte_s3) * 34'(sfd_s3);
	assign pgrass    = 34'(grase_s3) * 34'(sg_s3);
	assign grass_raw = pgrass[32:16];

	tswk_pkg::weights_t w_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4.sand  <= sand_s3;
			w_s4.rock  <= rock_s3;
			w_s4.dirt  <= pdirt[32:16];
			w_s4.grass <= (grass_raw < tswk_pkg::GRASS_FLOOR) ? tswk_pkg::GRASS_FLOOR : grass_raw;
		end
	end

	// stage 5: total
	tswk_pkg::weights_t w_s5;
	logic [18:0]        total_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s5     <= w_s4;
			total_s5 <= 19'(w_s4.grass) + 19'(w_s4.rock) + 19'(w_s4.dirt) + 19'(w_s4.sand);
		end
	end

	assign w     = w_s5;
	assign total = total_s5;

endmodule

// ----- rtl/core/tswk_scale_div.sv -----
// Pipelined divider: round_half_up(255 * w / total), one quotient bit per stage.
module tswk_scale_div (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] w,
	input  logic [18:0] total,
	output logic [7:0]  q
);

	localparam int SB = tswk_pkg::SCALE_BITS;

	logic [26:0] rem_s [0:SB];
	logic [19:0] den_s [0:SB];
	logic [7:0]  quo_s [0:SB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 27'({w, 9'b0}) - 27'({w, 1'b0}) + 27'(total);
			den_s[0] <= {total, 1'b0};
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= SB; k++) begin : g_stage
		logic [26:0] sh;
		logic        bit_k;
		assign sh    = 27'(den_s[k-1]) << (SB - k);
		assign bit_k = (rem_s[k-1] >= sh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= bit_k ? (rem_s[k-1] - sh) : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= {quo_s[k-1][6:0], bit_k};
			end
		end
	end

	assign q = quo_s[SB];

endmodule

// ----- rtl/core/terrain_splat_weight_kernel_top.sv -----
// Top level of the terrain splat weight kernel.
//  channel | signals                         | direction
//  in      | in_valid in_ready height slope  | item in
//  out     | out_valid out_ready *_weight    | item out
//  cfg     | cfg_we cfg_idx cfg_data         | register write
// One item per cycle while out is not stalled; 17 normalize, 5 ramp and 9 scale stages.
// Bit-serial dividers set the depth: one quotient bit per stage.
// Reset clears valid bits and registers to elev_min 0, ranges 65535.
// A stall on out holds the whole pipeline; in_ready drops with it.
module terrain_splat_weight_kernel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] height,
	input  logic [15:0] slope,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  grass_weight,
	output logic [7:0]  rock_weight,
	output logic [7:0]  dirt_weight,
	output logic [7:0]  sand_weight,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH = tswk_pkg::PIPE_DEPTH;

	logic [15:0] elev_min_q, elev_range_q, slope_max_q;
	logic [DEPTH-1:0] vld_s;
	logic        en;
	logic [15:0] num_e;
	logic [16:0] e_n, s_n;
	tswk_pkg::weights_t w;
	logic [18:0] total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elev_min_q   <= tswk_pkg::ELEV_MIN_RST;
			elev_range_q <= tswk_pkg::ELEV_RANGE_RST;
			slope_max_q  <= tswk_pkg::SLOPE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				tswk_pkg::CFG_ELEV_MIN:   elev_min_q   <= cfg_data;
				tswk_pkg::CFG_ELEV_RANGE: elev_range_q <= cfg_data;
				tswk_pkg::CFG_SLOPE_MAX:  slope_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !vld_s[DEPTH-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	assign num_e = (height > elev_min_q) ? (height - elev_min_q) : 16'd0;

	tswk_norm_div u_norm_e (
		.clk (clk),
		.en  (en),
		.num (num_e),
		.den (elev_range_q),
		.q   (e_n)
	);

	tswk_norm_div u_norm_s (
		.clk (clk),
		.en  (en),
		.num (slope),
		.den (slope_max_q),
		.q   (s_n)
	);

	tswk_ramp u_ramp (
		.clk   (clk),
		.en    (en),
		.e     (e_n),
		.s     (s_n),
		.w     (w),
		.total (total)
	);

	tswk_scale_div u_grass (
		.clk (clk), .en (en), .w (w.grass), .total (total), .q (grass_weight)
	);

	tswk_scale_div u_rock (
		.clk (clk), .en (en), .w (w.rock), .total (total), .q (rock_weight)
	);

	tswk_scale_div u_dirt (
		.clk (clk), .en (en), .w (w.dirt), .total (total), .q (dirt_weight)
	);

	tswk_scale_div u_sand (
		.clk (clk), .en (en), .w (w.sand), .total (total), .q (sand_weight)
	);

endmodule

// ----- rtl/core/tswk_checker.sv -----
// Port-level checker for the terrain splat weight kernel, bound to the top level.
`include "terrain_splat_weight_kernel_top_defines.svh"

module tswk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] height,
	input logic [15:0] slope,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  grass_weight,
	input logic [7:0]  rock_weight,
	input logic [7:0]  dirt_weight,
	input logic [7:0]  sand_weight,
	input logic        cfg_we,
	input logic [1:0]  cfg_idx,
	input logic [15:0] cfg_data
);

	logic [9:0] wsum;
	assign wsum = 10'(grass_weight) + 10'(rock_weight) + 10'(dirt_weight) + 10'(sand_weight);

	`TSWK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(grass_weight) && $stable(rock_weight) && $stable(dirt_weight) && $stable(sand_weight))
	`TSWK_ASSERT_NOW(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready))
	`TSWK_ASSERT_NOW(a_sum_range, out_valid, wsum >= 10'd253 && wsum <= 10'd257)
	`TSWK_ASSERT_NOW(a_grass_floor, out_valid, grass_weight != 8'd0)

endmodule

bind terrain_splat_weight_kernel_top tswk_checker u_tswk_checker (.*);
